@@ hw/rtl/ftrd_pkg.sv @@
// ----------------------------------------------------------------------------
// ftrd_pkg
// Shared types and constants for the fan tach rpm debounce block.
// ----------------------------------------------------------------------------
package ftrd_pkg;

  localparam int WIDTH_W = 20;
  localparam int QUOT_W  = 24;
  localparam int RPM_W   = 12;
  localparam int OUTC_W  = 2;
  localparam int DUTY_W  = 8;
  localparam int CAP_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int CNT_W   = $clog2(QUOT_W);

  // 60000000 / (width * 4) == 15000000 / width
  localparam logic [QUOT_W-1:0] DIVIDEND     = 24'd15000000;
  localparam logic [QUOT_W-1:0] ACCEPT_TOL   = 24'd100;
  localparam logic [QUOT_W-1:0] ACCEPT_LIMIT = 24'd2000;
  localparam logic [QUOT_W-1:0] FORCE_LIMIT  = 24'd2500;
  localparam logic [CNT_W-1:0]  LAST_STEP    = CNT_W'(QUOT_W - 1);

  localparam logic [OUTC_W-1:0] OUTC_SETTLED  = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FORCED   = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_DISABLED = 2'd2;

  localparam logic [CIDX_W-1:0] REG_FAN_CAP   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FAN1_DUTY = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FAN2_DUTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DECIDE
  } ftrd_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ftrd_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } ftrd_stat_t;

endpackage

@@ hw/rtl/fan_tach_rpm_debounce.sv @@
// ----------------------------------------------------------------------------
// fan_tach_rpm_debounce
// Fan speed from tach pulse width, with tolerance debounce and forced update.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                   | tuser
//  s_*     | in  | [19:0] pulse_width_us          | fan_select
//  m_*     | out | [11:0] rpm_value, [13:12] outc | fan_id
//  cfg_*   | in  | index 0 cap, 1 duty1, 2 duty2  | -
//
//  An item runs through accept, 24 steps of the bit-serial divider
//  (15000000 / width, one quotient bit a cycle), then the decide state.
//  The decide state waits while the output register is still full.
//  A new item is accepted once decide completes, even if a result waits.
//  Reset clears config, the stored rpm and the reject count.
module fan_tach_rpm_debounce import ftrd_pkg::*; #(
  parameter int MAX_TRIES = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] pulse_width_us
  input  logic        s_tuser,   // [0] fan_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] rpm_value, [13:12] outcome
  output logic        m_tuser,   // [0] fan_id
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ftrd_cmd_t          cmd;
  ftrd_stat_t         stat;
  logic [RPM_W-1:0]   rpm_value;
  logic [OUTC_W-1:0]  outcome;

  assign cfg_ready = !rst;

  ftrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftrd_dp #(
    .MAX_TRIES (MAX_TRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sel      (s_tuser),
    .in_width    (s_tdata[WIDTH_W-1:0]),
    .cmd         (cmd),
    .stat        (stat),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .out_fan_id  (m_tuser),
    .out_rpm     (rpm_value),
    .out_outcome (outcome)
  );

  assign m_tdata = {2'b00, outcome, rpm_value};

endmodule

@@ hw/rtl/ftrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftrd_ctrl
// Sequencer: accept an item, run the divider, then commit the decision.
// ----------------------------------------------------------------------------
module ftrd_ctrl import ftrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ftrd_stat_t stat,
  output ftrd_cmd_t  cmd
);

  ftrd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        cmd.load = s_tvalid && !rst;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      ST_DECIDE: begin
        cmd.commit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/ftrd_dp.sv @@
// ----------------------------------------------------------------------------
// ftrd_dp
// Datapath: config registers, restoring divider, debounce state and output.
// ----------------------------------------------------------------------------
module ftrd_dp import ftrd_pkg::*; #(
  parameter int MAX_TRIES = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [DUTY_W-1:0]  cfg_data,
  input  logic               in_sel,
  input  logic [WIDTH_W-1:0] in_width,
  input  ftrd_cmd_t          cmd,
  output ftrd_stat_t         stat,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic               out_fan_id,
  output logic [RPM_W-1:0]   out_rpm,
  output logic [OUTC_W-1:0]  out_outcome
);

  localparam int TRY_W = $clog2(MAX_TRIES + 1);
  localparam logic [TRY_W:0] TRY_MAX = (TRY_W+1)'(MAX_TRIES);

  logic [CAP_W-1:0]   fan_capability;
  logic [DUTY_W-1:0]  fan1_duty;
  logic [DUTY_W-1:0]  fan2_duty;

  logic               sel;
  logic               disabled;
  logic [WIDTH_W-1:0] width;
  logic [WIDTH_W-1:0] rem;
  logic [QUOT_W-1:0]  quot;
  logic [CNT_W-1:0]   count;

  logic [RPM_W-1:0]   last_rpm;
  logic [TRY_W-1:0]   tries_count;

  logic [WIDTH_W:0]   rem_shift;
  logic               rem_ge;
  logic [QUOT_W-1:0]  rpm;
  logic [QUOT_W-1:0]  last_ext;
  logic [QUOT_W-1:0]  diff;
  logic               accept;
  logic [TRY_W:0]     tries_inc;
  logic               force_out;
  logic               emit;
  logic [RPM_W-1:0]   rpm_res;
  logic [OUTC_W-1:0]  outc_res;
  logic               sel_disabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_capability <= '0;
      fan1_duty      <= '0;
      fan2_duty      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAN_CAP:   fan_capability <= cfg_data[CAP_W-1:0];
        REG_FAN1_DUTY: fan1_duty      <= cfg_data;
        REG_FAN2_DUTY: fan2_duty      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sel_disabled = in_sel ? ((fan2_duty == '0) || !fan_capability[1])
                               : ((fan1_duty == '0) || !fan_capability[0]);

  // one quotient bit per cycle
  assign rem_shift = {rem, quot[QUOT_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, width};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel      <= in_sel;
      disabled <= sel_disabled;
      width    <= in_width;
      rem      <= '0;
      quot     <= DIVIDEND;
    end else if (cmd.step) begin
      rem  <= rem_ge ? WIDTH_W'(rem_shift - {1'b0, width}) : rem_shift[WIDTH_W-1:0];
      quot <= {quot[QUOT_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      count <= '0;
    end else if (cmd.step) begin
      count <= count + CNT_W'(1);
    end
  end

  assign stat.div_last = cmd.step && (count == LAST_STEP);
  assign stat.out_free = !m_tvalid || m_tready;

  // decision
  assign rpm       = (width == '0) ? '0 : quot;
  assign last_ext  = QUOT_W'(last_rpm);
  assign diff      = (rpm > last_ext) ? rpm - last_ext : last_ext - rpm;
  assign accept    = (diff < ACCEPT_TOL) && (rpm < ACCEPT_LIMIT);
  assign tries_inc = {1'b0, tries_count} + (TRY_W+1)'(1);
  assign force_out = tries_inc >= TRY_MAX;

  always_comb begin
    emit     = 1'b1;
    rpm_res  = rpm[RPM_W-1:0];
    outc_res = OUTC_SETTLED;
    priority if (disabled) begin
      rpm_res  = '0;
      outc_res = OUTC_DISABLED;
    end else if (accept) begin
      outc_res = OUTC_SETTLED;
    end else if (force_out) begin
      rpm_res  = (rpm > FORCE_LIMIT) ? '0 : rpm[RPM_W-1:0];
      outc_res = OUTC_FORCED;
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rpm    <= '0;
      tries_count <= '0;
    end else if (cmd.commit) begin
      if (emit) begin
        tries_count <= '0;
        if (!disabled) last_rpm <= rpm_res;
      end else begin
        tries_count <= tries_inc[TRY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      out_fan_id  <= sel;
      out_rpm     <= rpm_res;
      out_outcome <= outc_res;
    end
  end

endmodule
